FILE: sv/dcts_pkg.sv
// Shared types, constants and angle tables for the decimal CORDIC tangent unit.
`default_nettype none
package dcts_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int LAST_STEP   = 9;
    localparam int THR_W       = 21;
    localparam int VEC_W       = 44;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    localparam logic [29:0] ATAN_Q30 [0:LAST_STEP] = '{
        30'd843314857, 30'd107018401, 30'd10737060, 30'd1073741, 30'd107374,
        30'd10737, 30'd1074, 30'd107, 30'd11, 30'd1
    };

    localparam logic [29:0] POW_Q30 [0:LAST_STEP] = '{
        30'd1073741823, 30'd107374182, 30'd10737418, 30'd1073742, 30'd107374,
        30'd10737, 30'd1074, 30'd107, 30'd11, 30'd1
    };

    localparam logic [29:0] DEC_DIV [0:LAST_STEP] = '{
        30'd1, 30'd10, 30'd100, 30'd1000, 30'd10000, 30'd100000, 30'd1000000,
        30'd10000000, 30'd100000000, 30'd1000000000
    };

    typedef enum logic [1:0] {
        CLS_NEG,
        CLS_SMALL,
        CLS_RUN
    } t_cls;

    typedef struct packed {
        logic [30:0] mag;
        t_cls        cls;
    } t_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEL,
        ST_DEC,
        ST_UPD,
        ST_POST,
        ST_TAN,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_ROOT,
        ST_LDC,
        ST_COS,
        ST_LDS,
        ST_SIN,
        ST_FIN,
        ST_DONE
    } t_state;

    function automatic logic [30:0] step_angle(input logic [3:0] k);
        logic [30:0] v;
        if (32'(k) < TABLE_DEPTH) begin
            v = {1'b0, ATAN_Q30[k]};
        end else begin
            v = (k == 4'd0) ? {1'b0, ONE_Q30[29:0]} + 31'd1 : {1'b0, POW_Q30[k]};
        end
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: sv/dcts_front.sv
// Front part: threshold register, item classification and a two-entry item queue.
`default_nettype none
module dcts_front import dcts_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] i_angle,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [20:0] i_cfg_data,
    output t_item            o_item,
    output logic             o_item_valid,
    input  wire logic        i_item_ready,
    output logic [20:0]      o_th
);

    logic [20:0] r_th;
    t_item       r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        w_push;
    logic        w_pop;
    t_item       w_new;

    assign o_cfg_ready  = 1'b1;
    assign o_th         = r_th;
    assign full         = (r_cnt == 2'd2);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];
    assign w_push       = push && !full;
    assign w_pop        = o_item_valid && i_item_ready;

    always_comb begin
        w_new.mag = i_angle[30:0];
        if (i_angle[31]) begin
            w_new.cls = CLS_NEG;
        end else if ({10'd0, r_th} > i_angle[30:0]) begin
            w_new.cls = CLS_SMALL;
        end else begin
            w_new.cls = CLS_RUN;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_th  <= 21'd1;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_th <= (i_cfg_data == 21'd0) ? 21'd1 : i_cfg_data;
            end
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_new;
        end
    end

endmodule
`default_nettype wire

FILE: sv/dcts_back.sv
// Back part: rotation sequencer, serial divider, square root and result register.
`default_nettype none
module dcts_back import dcts_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  t_item            i_item,
    input  wire logic        i_item_valid,
    output logic             o_item_ready,
    input  wire logic [20:0] i_th,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      o_tangent,
    output logic [30:0]      o_sine,
    output logic [30:0]      o_cosine,
    output logic             o_overflow
);

    t_state r_state;
    t_state n_state;

    logic [30:0]              r_an;
    logic [3:0]               r_k;
    logic signed [VEC_W-1:0]  r_x;
    logic signed [VEC_W-1:0]  r_y;
    logic [VEC_W-1:0]         r_qx;
    logic [VEC_W-1:0]         r_qy;
    logic [30:0]              r_rx;
    logic [30:0]              r_ry;
    logic [5:0]               r_cnt;
    logic [63:0]              r_dvd;
    logic [VEC_W-1:0]         r_dvs;
    logic [VEC_W-1:0]         r_rem;
    logic [63:0]              r_prod;
    logic [63:0]              r_acc;
    logic [34:0]              r_sr;
    logic [31:0]              r_root;
    logic [31:0]              r_tan;
    logic [30:0]              r_sin;
    logic [30:0]              r_cos;
    logic                     r_ovf;
    logic                     r_out_valid;
    logic [31:0]              r_out_tan;
    logic [30:0]              r_out_sin;
    logic [30:0]              r_out_cos;
    logic                     r_out_ovf;

    logic                     w_load_out;
    logic [30:0]              w_step;
    logic                     w_below;
    logic                     w_adv;
    logic [VEC_W-1:0]         w_ax;
    logic [VEC_W-1:0]         w_ay;
    logic [74:0]              w_dsx;
    logic [74:0]              w_dsy;
    logic signed [VEC_W-1:0]  w_dx;
    logic signed [VEC_W-1:0]  w_dy;
    logic signed [VEC_W-1:0]  w_yc;
    logic [VEC_W:0]           w_drem;
    logic                     w_dge;
    logic [VEC_W-1:0]         w_drem_n;
    logic [32:0]              w_x30;
    logic [32:0]              w_y30;
    logic [34:0]              w_srem;
    logic [34:0]              w_trial;
    logic                     w_sge;

    function automatic logic [74:0] dec_step4(input logic [30:0] rem, input logic [43:0] dvd,
                                              input logic [29:0] d);
        logic [30:0] r;
        logic [43:0] q;
        logic [30:0] t;
        r = rem;
        q = dvd;
        for (int i = 0; i < 4; i++) begin
            t = {r[29:0], q[43]};
            q = {q[42:0], 1'b0};
            if (t >= {1'b0, d}) begin
                t    = t - {1'b0, d};
                q[0] = 1'b1;
            end
            r = t;
        end
        return {r, q};
    endfunction

    assign w_step  = step_angle(r_k);
    assign w_below = (r_an < {10'd0, i_th});
    assign w_adv   = (r_k < 4'(LAST_STEP)) && (r_an < w_step);
    assign w_ax    = r_x[VEC_W-1] ? VEC_W'(-r_x) : VEC_W'(r_x);
    assign w_ay    = r_y[VEC_W-1] ? VEC_W'(-r_y) : VEC_W'(r_y);
    assign w_dsx   = dec_step4(r_rx, r_qx, DEC_DIV[r_k]);
    assign w_dsy   = dec_step4(r_ry, r_qy, DEC_DIV[r_k]);
    assign w_dx    = r_x[VEC_W-1] ? -$signed(r_qx) : $signed(r_qx);
    assign w_dy    = r_y[VEC_W-1] ? -$signed(r_qy) : $signed(r_qy);
    assign w_yc    = r_y[VEC_W-1] ? '0 : r_y;
    assign w_drem  = {r_rem, r_dvd[63]};
    assign w_dge   = (w_drem >= {1'b0, r_dvs});
    assign w_drem_n = w_dge ? VEC_W'(w_drem - {1'b0, r_dvs}) : w_drem[VEC_W-1:0];
    assign w_x30   = r_x[42:10];
    assign w_y30   = r_y[42:10];
    assign w_srem  = {r_sr[32:0], r_acc[63:62]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_sge   = (w_srem >= w_trial);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    n_state = (i_item.cls == CLS_RUN) ? ST_SEL : ST_DONE;
                end
            end
            ST_SEL: begin
                if (w_below) begin
                    n_state = ST_POST;
                end else if (!w_adv) begin
                    n_state = ST_DEC;
                end
            end
            ST_DEC:  n_state = (r_cnt == 6'd10) ? ST_UPD : ST_DEC;
            ST_UPD:  n_state = ST_SEL;
            ST_POST: n_state = (r_x <= 0) ? ST_DONE : ST_TAN;
            ST_TAN:  n_state = (r_cnt == 6'd63) ? ST_SQX : ST_TAN;
            ST_SQX:  n_state = ST_SQY;
            ST_SQY:  n_state = ST_SUM;
            ST_SUM:  n_state = ST_ROOT;
            ST_ROOT: n_state = (r_cnt == 6'd31) ? ST_LDC : ST_ROOT;
            ST_LDC:  n_state = (r_root == 32'd0) ? ST_DONE : ST_COS;
            ST_COS:  n_state = (r_cnt == 6'd63) ? ST_LDS : ST_COS;
            ST_LDS:  n_state = ST_SIN;
            ST_SIN:  n_state = (r_cnt == 6'd63) ? ST_FIN : ST_SIN;
            ST_FIN:  n_state = ST_DONE;
            ST_DONE: n_state = r_out_valid ? ST_DONE : ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_item_ready = (r_state == ST_IDLE);
        w_load_out   = (r_state == ST_DONE) && !r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_an  <= i_item.mag;
                r_k   <= 4'd0;
                r_x   <= VEC_W'(64'd1 << 40);
                r_y   <= '0;
                r_tan <= 32'd0;
                r_sin <= 31'd0;
                r_cos <= ONE_Q30;
                r_ovf <= 1'b0;
            end
            ST_SEL: begin
                if (!w_below) begin
                    if (w_adv) begin
                        r_k <= r_k + 4'd1;
                    end else begin
                        r_an  <= r_an - w_step;
                        r_qx  <= w_ax;
                        r_qy  <= w_ay;
                        r_rx  <= 31'd0;
                        r_ry  <= 31'd0;
                        r_cnt <= 6'd0;
                    end
                end
            end
            ST_DEC: begin
                r_rx  <= w_dsx[74:44];
                r_qx  <= w_dsx[43:0];
                r_ry  <= w_dsy[74:44];
                r_qy  <= w_dsy[43:0];
                r_cnt <= r_cnt + 6'd1;
            end
            ST_UPD: begin
                r_x <= r_x - w_dy;
                r_y <= r_y + w_dx;
            end
            ST_POST: begin
                if (r_x <= 0) begin
                    r_tan <= 32'hFFFF_FFFF;
                    r_sin <= ONE_Q30;
                    r_cos <= 31'd0;
                    r_ovf <= 1'b1;
                end else begin
                    r_y   <= w_yc;
                    r_dvd <= {5'd0, w_yc[42:0], 16'd0};
                    r_dvs <= r_x;
                    r_rem <= '0;
                    r_cnt <= 6'd0;
                end
            end
            ST_TAN, ST_COS, ST_SIN: begin
                r_rem <= w_drem_n;
                r_dvd <= {r_dvd[62:0], w_dge};
                r_cnt <= r_cnt + 6'd1;
            end
            ST_SQX: begin
                r_tan  <= (r_dvd[63:32] != 32'd0) ? 32'hFFFF_FFFF : r_dvd[31:0];
                r_ovf  <= (r_dvd[63:32] != 32'd0);
                r_prod <= 64'(w_x30 * w_x30);
            end
            ST_SQY: begin
                r_acc  <= r_prod;
                r_prod <= 64'(w_y30 * w_y30);
            end
            ST_SUM: begin
                r_acc  <= r_acc + r_prod;
                r_sr   <= 35'd0;
                r_root <= 32'd0;
                r_cnt  <= 6'd0;
            end
            ST_ROOT: begin
                r_sr   <= w_sge ? (w_srem - w_trial) : w_srem;
                r_root <= {r_root[30:0], w_sge};
                r_acc  <= {r_acc[61:0], 2'b00};
                r_cnt  <= r_cnt + 6'd1;
            end
            ST_LDC: begin
                r_cos <= ONE_Q30;
                r_sin <= 31'd0;
                r_dvd <= {1'b0, w_x30, 30'd0};
                r_dvs <= {12'd0, r_root};
                r_rem <= '0;
                r_cnt <= 6'd0;
            end
            ST_LDS: begin
                r_cos <= r_dvd[30:0];
                r_dvd <= {1'b0, w_y30, 30'd0};
                r_rem <= '0;
                r_cnt <= 6'd0;
            end
            ST_FIN: begin
                r_sin <= r_dvd[30:0];
            end
            ST_DONE: begin
                if (w_load_out) begin
                    r_out_tan <= r_tan;
                    r_out_sin <= r_sin;
                    r_out_cos <= r_cos;
                    r_out_ovf <= r_ovf;
                end
            end
            default: begin
                r_cnt <= 6'd0;
            end
        endcase
    end

    assign empty      = !r_out_valid;
    assign o_tangent  = r_out_tan;
    assign o_sine     = r_out_sin;
    assign o_cosine   = r_out_cos;
    assign o_overflow = r_out_ovf;

endmodule
`default_nettype wire

FILE: sv/decimal_cordic_tan_sin_cos_unit.sv
// Top level of the decimal CORDIC tangent, sine and cosine unit.
//
// Channel   Direction  Handshake                       Payload
// input     in         push / full                     i_angle
// result    out        empty / pop                     o_tangent, o_sine, o_cosine, o_overflow
// config    in         i_cfg_valid / o_cfg_ready       i_cfg_data (stop threshold)
//
// An item that rotates runs, per rotation step, a decimal divide of x and y and an update,
// with table index advances in between; then, if x is positive, up to three serial divides
// and a square root. Items that need no rotation skip these steps. Reset is synchronous
// and active low and empties both queues. The two-entry front queue keeps taking beats
// while a result waits for pop.
`default_nettype none
module decimal_cordic_tan_sin_cos_unit import dcts_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] i_angle,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      o_tangent,
    output logic [30:0]      o_sine,
    output logic [30:0]      o_cosine,
    output logic             o_overflow,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [20:0] i_cfg_data
);

    t_item       w_item;
    logic        w_item_valid;
    logic        w_item_ready;
    logic [20:0] w_th;

    dcts_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_angle      (i_angle),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_item_ready (w_item_ready),
        .o_th         (w_th)
    );

    dcts_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_item_ready (w_item_ready),
        .i_th         (w_th),
        .empty        (empty),
        .pop          (pop),
        .o_tangent    (o_tangent),
        .o_sine       (o_sine),
        .o_cosine     (o_cosine),
        .o_overflow   (o_overflow)
    );

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_overflow) |-> (o_tangent == 32'hFFFF_FFFF))
        else $error("overflow without saturated tangent");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_sine <= ONE_Q30) && (o_cosine <= ONE_Q30)))
        else $error("sine or cosine above one");

    a_zero_tan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_tangent == 32'd0)) |-> !o_overflow)
        else $error("overflow with zero tangent");

endmodule
`default_nettype wire

FILE: sim/decimal_cordic_tan_sin_cos_unit_tb.sv
// Testbench for the decimal CORDIC tangent, sine and cosine unit with a built-in predictor.
`default_nettype none
module decimal_cordic_tan_sin_cos_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_MAX  = 1686629713;
    localparam int STALL_LIMIT = 40000;

    localparam longint ROT_ANGLE [0:9] = '{
        843314857, 107018401, 10737060, 1073741, 107374, 10737, 1074, 107, 11, 1
    };
    localparam longint DEC_SCALE [0:9] = '{
        1, 10, 100, 1000, 10000, 100000, 1000000, 10000000, 100000000, 1000000000
    };

    typedef struct {
        logic [31:0] tangent;
        logic [30:0] sine;
        logic [30:0] cosine;
        logic        overflow;
    } t_trig;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [31:0] i_angle = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_tangent;
    logic [30:0] o_sine;
    logic [30:0] o_cosine;
    logic        o_overflow;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [20:0] i_cfg_data = '0;

    decimal_cordic_tan_sin_cos_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_angle     (i_angle),
        .empty       (empty),
        .pop         (pop),
        .o_tangent   (o_tangent),
        .o_sine      (o_sine),
        .o_cosine    (o_cosine),
        .o_overflow  (o_overflow),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [31:0] angle_queue[$];
    t_trig       trig_queue[$];
    logic [20:0] stop_thr = 21'd1;
    int          send_idle_pct = 28;
    int          recv_idle_pct = 75;
    bit          angle_taken = 1'b0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          neg_seen = 0;
    int          ovf_seen = 0;
    int          quiet_cycles = 0;

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic t_trig predict_trig(input logic [31:0] ang, input logic [20:0] thr);
        t_trig           r;
        longint          resid;
        longint          th;
        longint          x;
        longint          y;
        longint          t;
        int              k;
        longint unsigned ux;
        longint unsigned uy;
        longint unsigned q;
        longint unsigned x30;
        longint unsigned y30;
        longint unsigned rad;
        r.tangent = '0;
        r.sine = '0;
        r.cosine = 31'h4000_0000;
        r.overflow = 1'b0;
        if (ang[31]) return r;
        th = (thr == 0) ? 1 : longint'(thr);
        resid = longint'(ang);
        k = 0;
        x = 64'sd1 << 40;
        y = 0;
        while (resid >= th) begin
            while (k < 9 && resid < ROT_ANGLE[k]) k++;
            resid -= ROT_ANGLE[k];
            t = x;
            x = x - y / DEC_SCALE[k];
            y = y + t / DEC_SCALE[k];
        end
        if (x <= 0) begin
            r.tangent = 32'hFFFF_FFFF;
            r.sine = 31'h4000_0000;
            r.cosine = '0;
            r.overflow = 1'b1;
            return r;
        end
        if (y < 0) y = 0;
        ux = x;
        uy = y;
        q = (uy << 16) / ux;
        if (q > 64'hFFFF_FFFF) begin
            r.tangent = 32'hFFFF_FFFF;
            r.overflow = 1'b1;
        end else begin
            r.tangent = q[31:0];
        end
        x30 = ux >> 10;
        y30 = uy >> 10;
        rad = floor_sqrt(x30 * x30 + y30 * y30);
        if (rad != 0) begin
            q = (x30 << 30) / rad;
            r.cosine = q[30:0];
            q = (y30 << 30) / rad;
            r.sine = q[30:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want,
                 results_seen);
        mismatches++;
    endtask

    // Driver: one beat per accepted item, idling at random between beats.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            pop <= 1'b0;
        end else begin
            if (!(push && !angle_taken)) begin
                if (angle_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    push <= 1'b1;
                    i_angle <= angle_queue[0];
                end else begin
                    push <= 1'b0;
                end
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
        angle_taken = 1'b0;
    end

    // Monitor: predicts on each accepted angle and checks each popped result.
    always @(posedge i_clk) begin
        t_trig want;
        if (i_rst_n) begin
            quiet_cycles++;
            if (i_cfg_valid && o_cfg_ready) stop_thr = i_cfg_data;
            if (push && !full) begin
                trig_queue.push_back(predict_trig(i_angle, stop_thr));
                void'(angle_queue.pop_front());
                angle_taken = 1'b1;
                quiet_cycles = 0;
            end
            if (pop && !empty) begin
                quiet_cycles = 0;
                results_seen++;
                if (trig_queue.size() == 0) begin
                    report_mismatch("unexpected result", o_tangent, 0);
                end else begin
                    want = trig_queue.pop_front();
                    if (o_tangent !== want.tangent)
                        report_mismatch("tangent", o_tangent, want.tangent);
                    if (o_sine !== want.sine) report_mismatch("sine", o_sine, want.sine);
                    if (o_cosine !== want.cosine)
                        report_mismatch("cosine", o_cosine, want.cosine);
                    if (o_overflow !== want.overflow)
                        report_mismatch("overflow", o_overflow, want.overflow);
                    if (want.overflow) ovf_seen++;
                end
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (angle_queue.size() != 0 || trig_queue.size() != 0 || push)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [20:0] thr);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= thr;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_angle();
        int sel;
        int mag;
        sel = $urandom_range(99);
        if (sel < 50) mag = $urandom_range(ANGLE_MAX);
        else if (sel < 70) mag = $urandom_range(ANGLE_MAX) >> $urandom_range(30);
        else if (sel < 85) mag = ANGLE_MAX - $urandom_range(40000);
        else mag = -int'($urandom_range(ANGLE_MAX));
        if (mag < 0) neg_seen++;
        return mag;
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++) angle_queue.push_back(random_angle());
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (ROT_ANGLE[j]) angle_queue.push_back(32'(ROT_ANGLE[j]));
        angle_queue.push_back(32'd0);
        angle_queue.push_back(32'd2);
        angle_queue.push_back(32'd843314856);
        angle_queue.push_back(32'd1073741824);
        angle_queue.push_back(ANGLE_MAX);
        angle_queue.push_back(ANGLE_MAX - 1);
        angle_queue.push_back(ANGLE_MAX - 100);
        angle_queue.push_back(ANGLE_MAX - 5000);
        angle_queue.push_back(-1);
        angle_queue.push_back(-ANGLE_MAX);
        angle_queue.push_back(32'h8000_0001);
        neg_seen += 3;
        random_phase(60);

        write_threshold(21'd1048576);
        angle_queue.push_back(32'd1048575);
        angle_queue.push_back(32'd1048576);
        random_phase(60);

        send_idle_pct = 75;
        recv_idle_pct = 28;
        write_threshold(21'd1);
        random_phase(80);
        write_threshold(21'($urandom_range(1, 1048576)));
        random_phase(60);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_threshold(21'($urandom_range(1, 64)));
        random_phase(80);
        write_threshold(21'd1);
        random_phase(60);

        wait_drained();
        repeat (300) @(posedge i_clk);
        $display("Checked %0d results (%0d negative angles, %0d with overflow)",
                 results_seen, neg_seen, ovf_seen);
        $display("over six stop thresholds including both extremes and three idling mixes.");
        if (mismatches == 0 && trig_queue.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
